// ----- hw/rtl/pee_pkg.sv -----
// Package for the postfix expression evaluator: sizes, character codes, types.
package pee_pkg;

	// Sizes of the stack and of the fixed-point values.
	localparam int STACK_DEPTH   = 16;
	localparam int VALUE_WIDTH   = 48;
	localparam int FRACTION_BITS = 16;

	// Derived widths.
	localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W  = $clog2(STACK_DEPTH);
	localparam int SUM_W   = VALUE_WIDTH + 1;
	localparam int DIV_W   = VALUE_WIDTH + FRACTION_BITS;
	localparam int CNT_W   = $clog2(DIV_W + 1);
	localparam int WIDE_W  = 2 * VALUE_WIDTH + FRACTION_BITS;
	localparam int DIGIT_W = VALUE_WIDTH + FRACTION_BITS + 4;

	// ASCII codes of the characters that the evaluator understands.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Line status codes, as reported on the result channel.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_DIVZERO  = 2'd3
	} status_t;

	// Arithmetic operations.
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_LEFT,
		S_OPERAND,
		S_MAG_B,
		S_MUL,
		S_DIV,
		S_FINISH,
		S_RESULT
	} state_t;

endpackage

// ----- hw/rtl/postfix_expression_evaluator.sv -----
// Postfix expression evaluator: takes one character per transfer on the symbol channel and
// returns one result per line on the result channel. Digits, spaces, unknown characters,
// operators that find too few operands and every character after an error are handled in the
// idle state alone; + and - also pass through the operand-read states. The end-of-line mark
// passes through a result state and stays there while the result of the previous line still
// waits in the output register. Multiply and divide run on one shared adder under a small
// sequencer: a multiply as one shift-add step per cycle, a divide as one restoring quotient
// bit per cycle. The stack sits in a RAM with one read port, so the two operands are read
// one after the other. sym_stall is high while an operation is in progress
// and the input is taken again once the sequencer is back in its idle state. A result
// waits in an output register until it is taken; the next line's characters are accepted
// meanwhile, but a further end-of-line mark holds the input until that register is free. Values
// are signed fixed point with FRACTION_BITS fraction bits; the value field is zero whenever
// the status is not ok, and the first error of a line freezes the stack until end of line.
module postfix_expression_evaluator
	import pee_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sym_valid,
	output logic                          sym_stall,
	input  logic [7:0]                    symbol,
	input  logic                          end_of_line,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic signed [VALUE_WIDTH-1:0] value,
	output logic [1:0]                    status
);

	// Control state.
	state_t               state_q, state_d;
	logic [LEVEL_W-1:0]   level_q;
	status_t              line_status_q;
	status_t              fin_status_q;
	op_t                  op_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 res_valid_q;

	// Datapath registers.
	logic [VALUE_WIDTH-1:0]   a_q;
	logic [VALUE_WIDTH-1:0]   b_q;
	logic                     neg_q;
	logic [VALUE_WIDTH-1:0]   acc_q;
	logic [VALUE_WIDTH-1:0]   mq_q;
	logic [DIV_W-1:0]         dq_q;
	logic [VALUE_WIDTH-2:0]   rem_q;
	logic [VALUE_WIDTH-1:0]   value_q;
	status_t                  status_q;

	// Stack RAM ports.
	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic                   rd_en;
	logic [ADDR_W-1:0]      rd_addr;
	logic [VALUE_WIDTH-1:0] rd_data;

	// Shared adder.
	logic [SUM_W-1:0] add_x;
	logic [SUM_W-1:0] add_y;
	logic             add_sub;
	logic [SUM_W-1:0] sum;

	// Decoded input and derived values.
	logic                     sym_accept;
	logic                     is_digit;
	logic                     is_op;
	op_t                      sym_op;
	logic [7:0]               digit_diff;
	logic [DIGIT_W-1:0]       digit_wide;
	logic                     digit_fits;
	logic [LEVEL_W-1:0]       level_m1;
	logic [LEVEL_W-1:0]       level_m2;
	logic                     addsub_ovf;
	logic [VALUE_WIDTH:0]     div_trial;
	logic                     div_ge;
	logic [WIDE_W-1:0]        fin_wide;
	logic [VALUE_WIDTH-1:0]   fin_mag;
	logic                     fin_fits;
	logic                     res_load;

	pee_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Input handshake: characters are taken only in the idle state.
	assign sym_stall  = (state_q != S_IDLE);
	assign sym_accept = sym_valid && !sym_stall;

	// Character decode.
	always_comb begin
		is_digit   = (symbol >= CH_ZERO) && (symbol <= CH_NINE);
		digit_diff = symbol - CH_ZERO;
		digit_wide = DIGIT_W'(digit_diff[3:0]) << FRACTION_BITS;
		digit_fits = (digit_wide[DIGIT_W-1:VALUE_WIDTH-1] == '0);
		is_op      = 1'b1;
		sym_op     = OP_ADD;
		case (symbol)
			CH_PLUS:  sym_op = OP_ADD;
			CH_MINUS: sym_op = OP_SUB;
			CH_STAR:  sym_op = OP_MUL;
			CH_SLASH: sym_op = OP_DIV;
			default:  is_op = 1'b0;
		endcase
	end

	assign level_m1 = level_q - LEVEL_W'(1);
	assign level_m2 = level_q - LEVEL_W'(2);

	// The shared adder: x + y or x - y.
	assign sum = add_x + (add_y ^ {SUM_W{add_sub}}) + SUM_W'(add_sub);

	// Flags taken from the adder and from the loop registers.
	always_comb begin
		addsub_ovf = (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]);
		div_trial  = {1'b0, rem_q, dq_q[DIV_W-1]};
		div_ge     = !sum[VALUE_WIDTH];
		if (op_q == OP_MUL) begin
			fin_wide = WIDE_W'({acc_q, mq_q}) >> FRACTION_BITS;
		end else begin
			fin_wide = WIDE_W'(dq_q);
		end
		fin_mag  = fin_wide[VALUE_WIDTH-1:0];
		fin_fits = (fin_wide[WIDE_W-1:VALUE_WIDTH] == '0) &&
			(!fin_mag[VALUE_WIDTH-1] || (neg_q && (fin_mag[VALUE_WIDTH-2:0] == '0)));
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (sym_accept) begin
					if (end_of_line) begin
						state_d = S_RESULT;
					end else if (line_status_q == ST_OK && is_op && level_q >= LEVEL_W'(2)) begin
						state_d = S_RD_LEFT;
					end
				end
			end
			S_RD_LEFT: state_d = S_OPERAND;
			S_OPERAND: begin
				if (op_q == OP_ADD || op_q == OP_SUB) begin
					state_d = S_IDLE;
				end else if (op_q == OP_DIV && b_q == '0) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_MAG_B;
				end
			end
			S_MAG_B: state_d = (op_q == OP_MUL) ? S_MUL : S_DIV;
			S_MUL:   state_d = (cnt_q == CNT_W'(1)) ? S_FINISH : S_MUL;
			S_DIV:   state_d = (cnt_q == CNT_W'(1)) ? S_FINISH : S_DIV;
			S_FINISH: state_d = S_IDLE;
			S_RESULT: state_d = res_load ? S_IDLE : S_RESULT;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory and adder controls of each state.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = level_q[ADDR_W-1:0];
		wr_data = digit_wide[VALUE_WIDTH-1:0];
		rd_en   = 1'b0;
		rd_addr = level_m1[ADDR_W-1:0];
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		res_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (sym_accept) begin
					if (end_of_line) begin
						rd_en   = 1'b1;
						rd_addr = '0;
					end else if (line_status_q == ST_OK) begin
						if (is_digit && level_q != LEVEL_W'(STACK_DEPTH) && digit_fits) begin
							wr_en = 1'b1;
						end
						if (is_op && level_q >= LEVEL_W'(2)) begin
							rd_en = 1'b1;
						end
					end
				end
			end
			S_RD_LEFT: begin
				rd_en   = 1'b1;
				rd_addr = level_m2[ADDR_W-1:0];
			end
			S_OPERAND: begin
				if (op_q == OP_ADD || op_q == OP_SUB) begin
					add_x   = {rd_data[VALUE_WIDTH-1], rd_data};
					add_y   = {b_q[VALUE_WIDTH-1], b_q};
					add_sub = (op_q == OP_SUB);
					wr_en   = !addsub_ovf;
					wr_addr = level_m2[ADDR_W-1:0];
					wr_data = sum[VALUE_WIDTH-1:0];
				end else begin
					add_y   = {rd_data[VALUE_WIDTH-1], rd_data};
					add_sub = 1'b1;
				end
			end
			S_MAG_B: begin
				add_y   = {b_q[VALUE_WIDTH-1], b_q};
				add_sub = 1'b1;
			end
			S_MUL: begin
				add_x = {1'b0, acc_q};
				add_y = mq_q[0] ? {1'b0, b_q} : '0;
			end
			S_DIV: begin
				add_x   = div_trial;
				add_y   = {1'b0, b_q};
				add_sub = 1'b1;
			end
			S_FINISH: begin
				add_y   = {1'b0, fin_mag};
				add_sub = neg_q;
				wr_en   = fin_fits;
				wr_addr = level_m2[ADDR_W-1:0];
				wr_data = sum[VALUE_WIDTH-1:0];
			end
			S_RESULT: begin
				res_load = !res_valid_q || !res_stall;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			level_q       <= '0;
			line_status_q <= ST_OK;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (sym_accept) begin
						if (end_of_line) begin
							level_q       <= '0;
							line_status_q <= ST_OK;
						end else if (line_status_q == ST_OK) begin
							if (is_digit) begin
								if (level_q == LEVEL_W'(STACK_DEPTH) || !digit_fits) begin
									line_status_q <= ST_OVERFLOW;
								end else begin
									level_q <= level_q + LEVEL_W'(1);
								end
							end else if (is_op) begin
								if (level_q < LEVEL_W'(2)) begin
									line_status_q <= ST_INVALID;
								end
							end else if (symbol != CH_SPACE) begin
								line_status_q <= ST_INVALID;
							end
						end
					end
				end
				S_OPERAND: begin
					if (op_q == OP_ADD || op_q == OP_SUB) begin
						if (addsub_ovf) begin
							line_status_q <= ST_OVERFLOW;
						end else begin
							level_q <= level_m1;
						end
					end else if (op_q == OP_DIV && b_q == '0) begin
						line_status_q <= ST_DIVZERO;
					end
				end
				S_FINISH: begin
					if (fin_fits) begin
						level_q <= level_m1;
					end else begin
						line_status_q <= ST_OVERFLOW;
					end
				end
				default: begin
					level_q <= level_q;
				end
			endcase
		end
	end

	// Operands, loop registers and the result register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= sym_op;
				if (line_status_q != ST_OK) begin
					fin_status_q <= line_status_q;
				end else if (level_q != LEVEL_W'(1)) begin
					fin_status_q <= ST_INVALID;
				end else begin
					fin_status_q <= ST_OK;
				end
			end
			S_RD_LEFT: begin
				// Right operand arrives first.
				b_q <= rd_data;
			end
			S_OPERAND: begin
				a_q   <= rd_data[VALUE_WIDTH-1] ? sum[VALUE_WIDTH-1:0] : rd_data;
				neg_q <= rd_data[VALUE_WIDTH-1] ^ b_q[VALUE_WIDTH-1];
			end
			S_MAG_B: begin
				b_q   <= b_q[VALUE_WIDTH-1] ? sum[VALUE_WIDTH-1:0] : b_q;
				acc_q <= '0;
				mq_q  <= a_q;
				dq_q  <= DIV_W'(a_q) << FRACTION_BITS;
				rem_q <= '0;
				cnt_q <= (op_q == OP_MUL) ? CNT_W'(VALUE_WIDTH) : CNT_W'(DIV_W);
			end
			S_MUL: begin
				// Add the multiplicand on a set multiplier bit, then shift the pair right.
				acc_q <= sum[VALUE_WIDTH:1];
				mq_q  <= {sum[0], mq_q[VALUE_WIDTH-1:1]};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_DIV: begin
				// Restoring step: keep the difference when the trial is not below the divisor.
				rem_q <= div_ge ? sum[VALUE_WIDTH-2:0] : div_trial[VALUE_WIDTH-2:0];
				dq_q  <= {dq_q[DIV_W-2:0], div_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_RESULT: begin
				if (res_load) begin
					value_q  <= (fin_status_q == ST_OK) ? rd_data : '0;
					status_q <= fin_status_q;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// Result channel.
	assign res_valid = res_valid_q;
	assign value     = value_q;
	assign status    = status_q;

endmodule

// ----- hw/rtl/pee_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pee_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
